@@ sv/bcm_pkg.sv @@
// Package for block_color_mad: beat types, state enum and fixed constants.
package bcm_pkg;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned MAD_W = 15;
	localparam int unsigned CNT_OUT_W = 13;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} pix_t;

	typedef struct packed {
		logic [MAD_W-1:0]     mad_q8;
		logic [CNT_OUT_W-1:0] pixel_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIVM,
		ST_SCAN,
		ST_DIVT,
		ST_OUT
	} back_st_t;
endpackage

@@ sv/bcm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bcm_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/bcm_front.sv @@
// Front end of block_color_mad: input skid queue of two pixel beats.
module bcm_front import bcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pix_t in_data,
	output logic q_valid,
	input  logic q_take,
	output pix_t q_data
);
	pix_t       ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = cnt_q[1];
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

@@ sv/bcm_back.sv @@
// Back end of block_color_mad: store, sums, means, deviation scan, final divide.
module bcm_back import bcm_pkg::*; #(
	parameter int unsigned MAX_PIXELS = 4096,
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_take,
	input  pix_t q_data,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);
	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned SW = CHAN_W + CW;
	localparam int unsigned MW = CHAN_W + FRAC_BITS;
	localparam int unsigned NW = SW + FRAC_BITS;
	localparam int unsigned TW = MW + CW + 2;
	localparam int unsigned DW = CW + 2;
	localparam logic [CW-1:0] MAXP = CW'(MAX_PIXELS);

	back_st_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] sum_q [3];
	logic [MW-1:0] mean_q [3];
	logic [NW-1:0] dq_q [3];
	logic [NW-1:0] drem_q [3];
	logic [TW-1:0] tq_q;
	logic [TW-1:0] trem_q;
	logic [DW-1:0] den_q;
	logic [$clog2(TW+1)-1:0] bit_q;
	logic [AW-1:0] scan_q;
	logic          rd_ok_s1, rd_ok_s2;
	logic [TW-1:0] tot_q;
	logic [3*CHAN_W-1:0] rdata;
	logic [AW-1:0] raddr;
	logic          wr_en;
	logic [MAD_W-1:0] mad_c;

	assign wr_en = (st_q == ST_LOAD) && q_valid && (cnt_q < MAXP);
	assign raddr = scan_q;

	bcm_ram #(.WIDTH(3*CHAN_W), .DEPTH(MAX_PIXELS)) u_ram (
		.clk(clk), .we(wr_en), .waddr(cnt_q[AW-1:0]),
		.wdata({q_data.red, q_data.green, q_data.blue}),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		st_d = st_q;
		q_take = 1'b0;
		unique case (st_q)
			ST_LOAD: begin
				q_take = q_valid;
				if (q_valid && q_data.last) begin
					st_d = ST_DIVM;
				end
			end
			ST_DIVM: if (bit_q == '0) st_d = ST_SCAN;
			ST_SCAN: if (!rd_ok_s1 && !rd_ok_s2 && scan_q == '0) st_d = ST_DIVT;
			ST_DIVT: if (bit_q == '0) st_d = ST_OUT;
			ST_OUT: if (!out_stall) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	assign out_valid = st_q == ST_OUT;
	assign mad_c = (tq_q > TW'(2**MAD_W - 1)) ? {MAD_W{1'b1}} : tq_q[MAD_W-1:0];
	always_comb begin
		out_data.mad_q8 = mad_c;
		out_data.pixel_count = CNT_OUT_W'(cnt_q);
	end

	function automatic logic [MW-1:0] absd(input logic [CHAN_W-1:0] v,
		input logic [MW-1:0] m);
		logic [MW-1:0] vs;
		vs = MW'({v, {FRAC_BITS{1'b0}}});
		return (vs >= m) ? vs - m : m - vs;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
			bit_q <= '0;
			scan_q <= '0;
			rd_ok_s1 <= 1'b0;
			rd_ok_s2 <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_LOAD: begin
					if (wr_en) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q[0] <= sum_q[0] + SW'(q_data.red);
						sum_q[1] <= sum_q[1] + SW'(q_data.green);
						sum_q[2] <= sum_q[2] + SW'(q_data.blue);
					end
					if (q_valid && q_data.last) begin
						bit_q <= ($clog2(TW+1))'(NW);
					end
				end
				ST_DIVM: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						scan_q <= '0;
						rd_ok_s1 <= 1'b1;
					end
				end
				ST_SCAN: begin
					rd_ok_s2 <= rd_ok_s1;
					if (rd_ok_s1) begin
						if (32'(scan_q) + 1 >= 32'(cnt_q)) begin
							rd_ok_s1 <= 1'b0;
							scan_q <= '0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (!rd_ok_s1 && !rd_ok_s2 && scan_q == '0) begin
						bit_q <= ($clog2(TW+1))'(TW);
					end
				end
				ST_DIVT: bit_q <= bit_q - 1'b1;
				ST_OUT: begin
					if (!out_stall) begin
						cnt_q <= '0;
						for (int c = 0; c < 3; c++) sum_q[c] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// restoring dividers and deviation accumulator (payload, no reset)
	always_ff @(posedge clk) begin
		logic [NW:0]   r;
		logic [NW-1:0] sn;
		logic [TW:0]   tr;
		unique case (st_q)
			ST_LOAD: begin
				for (int c = 0; c < 3; c++) begin
					dq_q[c] <= '0;
					drem_q[c] <= '0;
				end
				tot_q <= '0;
			end
			ST_DIVM: begin
				if (bit_q != '0) begin
					for (int c = 0; c < 3; c++) begin
						sn = {sum_q[c], {FRAC_BITS{1'b0}}};
						r = {drem_q[c], sn[bit_q - 1'b1]};
						if (r >= (NW+1)'(cnt_q)) begin
							drem_q[c] <= NW'(r - (NW+1)'(cnt_q));
							dq_q[c] <= {dq_q[c][NW-2:0], 1'b1};
						end else begin
							drem_q[c] <= r[NW-1:0];
							dq_q[c] <= {dq_q[c][NW-2:0], 1'b0};
						end
					end
				end else begin
					for (int c = 0; c < 3; c++) mean_q[c] <= dq_q[c][MW-1:0];
				end
			end
			ST_SCAN: begin
				if (rd_ok_s2) begin
					tot_q <= tot_q + TW'(absd(rdata[3*CHAN_W-1:2*CHAN_W], mean_q[0]))
						+ TW'(absd(rdata[2*CHAN_W-1:CHAN_W], mean_q[1]))
						+ TW'(absd(rdata[CHAN_W-1:0], mean_q[2]));
				end
				tq_q <= '0;
				trem_q <= '0;
				den_q <= DW'(cnt_q) + DW'({cnt_q, 1'b0});
			end
			ST_DIVT: begin
				if (bit_q != '0) begin
					tr = {trem_q, tot_q[bit_q - 1'b1]};
					if (tr >= (TW+1)'(den_q)) begin
						trem_q <= TW'(tr - (TW+1)'(den_q));
						tq_q <= {tq_q[TW-2:0], 1'b1};
					end else begin
						trem_q <= tr[TW-1:0];
						tq_q <= {tq_q[TW-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end
endmodule

@@ sv/block_color_mad.sv @@
// Top level of block_color_mad: mean absolute deviation of one RGB block.
//  channel | dir | payload | handshake
//  in      | in  | pix_t   | in_valid / in_stall
//  out     | out | res_t   | out_valid / out_stall
// The back end takes each pixel from the two-beat queue in its load state, and
// the queue lets the feeder run ahead. After the last pixel come the mean
// divide, the memory scan and the final divide; then the result holds and
// waits under out_stall.
// Reset clears counts and sums; the pixel memory needs no clearing.
module block_color_mad import bcm_pkg::*; #(
	parameter int unsigned MAX_PIXELS = 4096,
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pix_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);
	logic q_valid, q_take;
	pix_t q_data;

	bcm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
	);

	bcm_back #(.MAX_PIXELS(MAX_PIXELS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);
endmodule

@@ tb/tb_block_color_mad.sv @@
// Testbench for block_color_mad: directed table then random RGB blocks, checked against a predictor.
`timescale 1ns / 1ps
module tb_block_color_mad;
	import bcm_pkg::*;

	localparam int unsigned MAXPX = 4096;
	localparam int unsigned FRAC = 8;
	localparam int unsigned RANDOM_BEATS = 1100;
	localparam int unsigned WATCHDOG_LIMIT = 200000;
	// back end after the last pixel: mean divide, scan, final divide
	localparam int unsigned DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pix_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_t out_data;

	always #4 clk = ~clk;

	block_color_mad #(.MAX_PIXELS(MAXPX), .FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state: pixels of the open block and their channel sums
	logic [23:0] block_pixels [MAXPX];
	int unsigned block_len;
	longint unsigned sum_r, sum_g, sum_b;
	res_t mad_expected [$];
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// directed rows: beat plus an optional typed-in result
	typedef struct {
		pix_t beat;
		bit   has_fixed;
		res_t fixed;
	} dir_row_t;

	function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// fold one pixel into the open block; queue the MAD when it closes
	function automatic void predict_mad(pix_t p);
		longint unsigned n, mr, mg, mb, total, q;
		res_t r;
		if (block_len < MAXPX) begin
			block_pixels[block_len] = {p.red, p.green, p.blue};
			block_len++;
			sum_r += p.red;
			sum_g += p.green;
			sum_b += p.blue;
		end
		if (!p.last)
			return;
		n = block_len;
		total = 0;
		q = 0;
		if (n != 0) begin
			mr = (sum_r << FRAC) / n;
			mg = (sum_g << FRAC) / n;
			mb = (sum_b << FRAC) / n;
			for (int unsigned i = 0; i < n; i++) begin
				total += abs_diff(longint'(block_pixels[i][23:16]) << FRAC, mr);
				total += abs_diff(longint'(block_pixels[i][15:8]) << FRAC, mg);
				total += abs_diff(longint'(block_pixels[i][7:0]) << FRAC, mb);
			end
			q = total / (3 * n);
		end
		if (q > 32767)
			q = 32767;
		r.mad_q8 = q[MAD_W-1:0];
		r.pixel_count = n[CNT_OUT_W-1:0];
		mad_expected.push_back(r);
		block_len = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
	endfunction

	// result side: check at the rising edge, choose next stall at the falling edge
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (mad_expected.size() == 0) begin
				$error("unexpected result mad_q8=%0d pixel_count=%0d",
					out_data.mad_q8, out_data.pixel_count);
				errors++;
			end else begin
				e = mad_expected.pop_front();
				if (out_data.mad_q8 !== e.mad_q8) begin
					$error("mad_q8 expected %0d actual %0d", e.mad_q8, out_data.mad_q8);
					errors++;
				end
				if (out_data.pixel_count !== e.pixel_count) begin
					$error("pixel_count expected %0d actual %0d",
						e.pixel_count, out_data.pixel_count);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// drive one beat, with random gaps before it; predicted on acceptance
	task automatic send_pixel(pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data = p;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_mad(p);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (mad_expected.size() != 0)
			@(negedge clk);
	endtask

	function automatic pix_t rand_pixel(bit last);
		pix_t p;
		p.red = 8'($urandom_range(255));
		p.green = 8'($urandom_range(255));
		p.blue = 8'($urandom_range(255));
		p.last = last;
		return p;
	endfunction

	// a block of random length; mostly small, with flat or extreme colour now and then
	task automatic send_block(int unsigned len, ref int unsigned sent);
		int unsigned style;
		pix_t p;
		style = $urandom_range(3);
		p = rand_pixel(1'b0);
		for (int unsigned i = 0; i < len; i++) begin
			if (style != 0)
				p = rand_pixel(1'b0);
			if (style == 3) begin
				p.red = {8{p.red[0]}};
				p.green = {8{p.green[0]}};
				p.blue = {8{p.blue[0]}};
			end
			p.last = (i == len - 1);
			send_pixel(p);
			sent++;
		end
	endtask

	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		int unsigned sent;
		int unsigned len;
		block_len = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single-pixel blocks give zero MAD; then a black/white pair
		row.has_fixed = 1'b1;
		row.beat = '{8'h00, 8'h00, 8'h00, 1'b1}; row.fixed = '{15'd0, 13'd1}; rows.push_back(row);
		row.beat = '{8'hff, 8'hff, 8'hff, 1'b1}; row.fixed = '{15'd0, 13'd1}; rows.push_back(row);
		row.has_fixed = 1'b0;
		row.beat = '{8'h00, 8'h00, 8'h00, 1'b0}; rows.push_back(row);
		row.has_fixed = 1'b1;
		// mean 127.5 per channel, every deviation 127.5 -> 0x7f80
		row.beat = '{8'hff, 8'hff, 8'hff, 1'b1}; row.fixed = '{15'd32640, 13'd2}; rows.push_back(row);
		row.has_fixed = 1'b0;
		row.beat = '{8'haa, 8'h55, 8'h0f, 1'b0}; rows.push_back(row);
		row.beat = '{8'h55, 8'haa, 8'hf0, 1'b0}; rows.push_back(row);
		row.beat = '{8'h01, 8'h80, 8'hfe, 1'b1}; rows.push_back(row);
		row.beat = '{8'h10, 8'h20, 8'h30, 1'b0}; rows.push_back(row);
		row.beat = '{8'h10, 8'h20, 8'h30, 1'b0}; rows.push_back(row);
		row.has_fixed = 1'b1;
		row.beat = '{8'h10, 8'h20, 8'h30, 1'b1}; row.fixed = '{15'd0, 13'd3}; rows.push_back(row);
		foreach (rows[i]) begin
			if (rows[i].has_fixed) begin
				// the typed-in value must agree with the predictor too
				send_pixel(rows[i].beat);
				if (mad_expected[$] != rows[i].fixed) begin
					$error("mad_q8 expected %0d actual %0d (table)",
						rows[i].fixed.mad_q8, mad_expected[$].mad_q8);
					errors++;
				end
			end else
				send_pixel(rows[i].beat);
		end
		wait_drained();

		// random blocks across the idling phases
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 57) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 29 : 57) : 0;
			while (sent < (ph + 1) * RANDOM_BEATS / 4) begin
				len = ($urandom_range(15) == 0) ? $urandom_range(200, 64)
					: $urandom_range(12, 1);
				send_block(len, sent);
				// sender holds off until the pipe is empty now and then
				if ($urandom_range(9) == 0)
					wait_drained();
			end
		end
		recv_stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && mad_expected.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/bcm_pkg.sv
sv/bcm_ram.sv
sv/bcm_front.sv
sv/bcm_back.sv
sv/block_color_mad.sv
tb/tb_block_color_mad.sv
